@@ src/dpt_pkg.sv @@
// Shared types and constants for the disparity to point triangulator.
// Used by dpt_divider and disparity_to_point_triangulator_top; no dependencies.
package dpt_pkg;

    localparam int CFG_W    = 24;
    localparam int DISP_W   = 16;
    localparam int COLOR_W  = 8;
    localparam int DU_W     = 25;
    localparam int FSUM_W   = 25;
    localparam int PROD_W   = 50;
    localparam int NUM_W    = 45;
    localparam int DEN_W    = 15;
    localparam int QUO_W    = 32;
    localparam int RES_W    = 32;
    localparam int M_DATA_W = 3 * RES_W + 3 * COLOR_W;

    localparam int PRE_LAT   = 3;
    localparam int DIV_LAT   = QUO_W + 2;
    localparam int TOTAL_LAT = PRE_LAT + DIV_LAT;

    localparam logic [RES_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [RES_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        CFG_FOCAL_X     = 3'd0,
        CFG_FOCAL_Y     = 3'd1,
        CFG_BASELINE    = 3'd2,
        CFG_CENTER_X    = 3'd3,
        CFG_CENTER_Y    = 3'd4,
        CFG_MASK_ENABLE = 3'd5
    } cfg_index_e;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic             neg;
        logic [DEN_W-1:0] den;
    } div_op_t;

    typedef struct packed {
        logic               valid;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } side_t;

endpackage

@@ src/dpt_divider.sv @@
// Pipelined restoring divider with signed saturation to 32 bits, one quotient bit per stage.
// Depends on dpt_pkg.
module dpt_divider (
    input  logic                       aclk,
    input  logic                       ce,
    input  dpt_pkg::div_op_t           op,
    output logic [dpt_pkg::RES_W-1:0]  result
);
    import dpt_pkg::*;

    logic [DEN_W-1:0] den_reg  [0:QUO_W-1];
    logic [DEN_W-1:0] rem_reg  [0:QUO_W-1];
    logic [QUO_W-1:0] work_reg [0:QUO_W];
    logic             sat_reg  [0:QUO_W];
    logic             neg_reg  [0:QUO_W];
    logic [RES_W-1:0] result_reg;
    logic [RES_W-1:0] result_next;
    logic [DEN_W-1:0] head;

    assign head = DEN_W'(op.num[NUM_W-1:QUO_W]);

    // A quotient of 2^32 or more is known up front and saturates directly.
    always_ff @(posedge aclk) begin
        if (ce) begin
            den_reg[0]  <= op.den;
            rem_reg[0]  <= head;
            work_reg[0] <= op.num[QUO_W-1:0];
            sat_reg[0]  <= (head >= op.den);
            neg_reg[0]  <= op.neg;
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
        logic [DEN_W:0]   trial;
        logic [DEN_W-1:0] diff;
        logic             ge;

        assign trial = {rem_reg[k-1], work_reg[k-1][QUO_W-1]};
        assign diff  = trial[DEN_W-1:0] - den_reg[k-1];
        assign ge    = (trial >= {1'b0, den_reg[k-1]});

        always_ff @(posedge aclk) begin
            if (ce) begin
                work_reg[k] <= {work_reg[k-1][QUO_W-2:0], ge};
                sat_reg[k]  <= sat_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
            end
        end

        if (k < QUO_W) begin : g_carry
            always_ff @(posedge aclk) begin
                if (ce) begin
                    den_reg[k] <= den_reg[k-1];
                    rem_reg[k] <= ge ? diff : trial[DEN_W-1:0];
                end
            end
        end
    end

    always_comb begin
        if (sat_reg[QUO_W]) begin
            result_next = neg_reg[QUO_W] ? SAT_MIN : SAT_MAX;
        end else if (!neg_reg[QUO_W]) begin
            result_next = work_reg[QUO_W][QUO_W-1] ? SAT_MAX : work_reg[QUO_W];
        end else if (work_reg[QUO_W][QUO_W-1] && (|work_reg[QUO_W][QUO_W-2:0])) begin
            result_next = SAT_MIN;
        end else begin
            result_next = -work_reg[QUO_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

@@ src/disparity_to_point_triangulator_top.sv @@
// Top level of the disparity to point triangulator: stream ports, configuration registers,
// operand pipeline and three dividers. Depends on dpt_pkg and dpt_divider.
//
// Each input beat is one pixel; a pixel with positive disparity that is not masked out gives
// one output beat with the point (x, y, z) in signed Q16.16 and its color, in input order.
// The block takes one pixel per clock while the output is not stalled: registers first form
// the operands and products, then the dividers divide by disparity, one quotient
// bit per pipeline stage. The whole pipeline holds while the output beat is not taken.
// Configuration writes are taken every cycle and apply to pixels accepted after them.
module disparity_to_point_triangulator_top #(
    parameter int COORD_WIDTH = 13
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // col, row, disp_value, red, green, blue, zero padding
    input  logic [((2*COORD_WIDTH+40+7)/8)*8-1:0] s_tdata,
    // mask_bit
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // point_x, point_y, point_z, out_red, out_green, out_blue
    output logic [dpt_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [2:0]                       cfg_index,
    input  logic [dpt_pkg::CFG_W-1:0]        cfg_data
);
    import dpt_pkg::*;

    localparam int CW = COORD_WIDTH;

    logic [CFG_W-1:0]        focal_x_reg;
    logic [CFG_W-1:0]        focal_y_reg;
    logic signed [CFG_W-1:0] baseline_reg;
    logic [CFG_W-1:0]        center_x_reg;
    logic [CFG_W-1:0]        center_y_reg;
    logic                    mask_enable_reg;

    logic [CW-1:0]      col;
    logic [CW-1:0]      row;
    logic [DISP_W-1:0]  disp;
    logic               keep;
    logic               ce;

    side_t                    side_reg [0:TOTAL_LAT-1];
    logic signed [DU_W-1:0]   du1_reg;
    logic signed [DU_W-1:0]   dv1_reg;
    logic [FSUM_W-1:0]        fsum1_reg;
    logic signed [CFG_W-1:0]  bl1_reg;
    logic [DEN_W-1:0]         den1_reg;
    logic signed [PROD_W-1:0] px2_reg;
    logic signed [PROD_W-1:0] py2_reg;
    logic signed [PROD_W-1:0] pz2_reg;
    logic [DEN_W-1:0]         den2_reg;
    logic [PROD_W-1:0]        mag_x;
    logic [PROD_W-1:0]        mag_y;
    logic [PROD_W-1:0]        mag_z;
    div_op_t                  op_x_reg;
    div_op_t                  op_y_reg;
    div_op_t                  op_z_reg;
    logic [RES_W-1:0]         res_x;
    logic [RES_W-1:0]         res_y;
    logic [RES_W-1:0]         res_z;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg     <= CFG_W'(256);
            focal_y_reg     <= CFG_W'(256);
            baseline_reg    <= '0;
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            mask_enable_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FOCAL_X:     focal_x_reg     <= cfg_data;
                CFG_FOCAL_Y:     focal_y_reg     <= cfg_data;
                CFG_BASELINE:    baseline_reg    <= cfg_data;
                CFG_CENTER_X:    center_x_reg    <= cfg_data;
                CFG_CENTER_Y:    center_y_reg    <= cfg_data;
                CFG_MASK_ENABLE: mask_enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign col  = s_tdata[CW-1:0];
    assign row  = s_tdata[2*CW-1:CW];
    assign disp = s_tdata[2*CW+DISP_W-1:2*CW];

    assign keep = s_tvalid && !disp[DISP_W-1] && (disp != '0)
                  && !(mask_enable_reg && !s_tuser[0]);

    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TOTAL_LAT; i++) begin
                side_reg[i].valid <= 1'b0;
            end
        end else if (ce) begin
            side_reg[0].valid <= keep;
            side_reg[0].red   <= s_tdata[2*CW+23:2*CW+16];
            side_reg[0].green <= s_tdata[2*CW+31:2*CW+24];
            side_reg[0].blue  <= s_tdata[2*CW+39:2*CW+32];
            for (int i = 1; i < TOTAL_LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            du1_reg   <= $signed(DU_W'({col, 8'h00})) - $signed(DU_W'(center_x_reg));
            dv1_reg   <= $signed(DU_W'({row, 8'h00})) - $signed(DU_W'(center_y_reg));
            fsum1_reg <= FSUM_W'(focal_x_reg) + FSUM_W'(focal_y_reg);
            bl1_reg   <= baseline_reg;
            den1_reg  <= disp[DEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            px2_reg  <= du1_reg * bl1_reg;
            py2_reg  <= dv1_reg * bl1_reg;
            pz2_reg  <= $signed({1'b0, fsum1_reg}) * bl1_reg;
            den2_reg <= den1_reg;
        end
    end

    assign mag_x = px2_reg[PROD_W-1] ? PROD_W'(-px2_reg) : PROD_W'(px2_reg);
    assign mag_y = py2_reg[PROD_W-1] ? PROD_W'(-py2_reg) : PROD_W'(py2_reg);
    assign mag_z = pz2_reg[PROD_W-1] ? PROD_W'(-pz2_reg) : PROD_W'(pz2_reg);

    // Dividing by 16*d (32*d for depth) is a shift followed by a divide by d.
    always_ff @(posedge aclk) begin
        if (ce) begin
            op_x_reg.num <= mag_x[NUM_W+3:4];
            op_x_reg.neg <= px2_reg[PROD_W-1];
            op_x_reg.den <= den2_reg;
            op_y_reg.num <= mag_y[NUM_W+3:4];
            op_y_reg.neg <= !py2_reg[PROD_W-1];
            op_y_reg.den <= den2_reg;
            op_z_reg.num <= mag_z[PROD_W-1:5];
            op_z_reg.neg <= pz2_reg[PROD_W-1];
            op_z_reg.den <= den2_reg;
        end
    end

    dpt_divider u_div_x (
        .aclk   (aclk),
        .ce     (ce),
        .op     (op_x_reg),
        .result (res_x)
    );

    dpt_divider u_div_y (
        .aclk   (aclk),
        .ce     (ce),
        .op     (op_y_reg),
        .result (res_y)
    );

    dpt_divider u_div_z (
        .aclk   (aclk),
        .ce     (ce),
        .op     (op_z_reg),
        .result (res_z)
    );

    assign m_tvalid = side_reg[TOTAL_LAT-1].valid;
    assign m_tdata  = {side_reg[TOTAL_LAT-1].blue, side_reg[TOTAL_LAT-1].green,
                       side_reg[TOTAL_LAT-1].red, res_z, res_y, res_x};

    a_reset_clears_output : assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_keep_enters_pipe : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (side_reg[0].valid == $past(keep)))
        else $error("pixel filter result lost at pipeline entry");

    a_stall_holds_pipe : assert property (@(posedge aclk) disable iff (!aresetn)
        (!ce && aresetn) |=> (side_reg[1].valid == $past(side_reg[1].valid)))
        else $error("pipeline moved during a stall");

endmodule
